FILE: rtl/visited_tile_direction_hash_set_unit_macros.svh
// Assertion macros for the visited tile/direction hash set.
// Needs a clk and an active-high rst in the including module's scope.
`ifndef VISITED_TILE_DIRECTION_HASH_SET_UNIT_MACROS_SVH
`define VISITED_TILE_DIRECTION_HASH_SET_UNIT_MACROS_SVH
`ifndef SYNTH
`define VTD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define VTD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define VTD_ASSERT_IMP(lbl, ante, cons)
`define VTD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/vtd_pkg.sv
// Shared constants, codes and the bucket hash for the visited tile/direction set.
// No dependencies.
package vtd_pkg;

  // bucket count is a power of two
  localparam int BKT_AW    = 10;
  localparam int BKT_COUNT = 1 << BKT_AW;

  localparam int LNK_COUNT = 1024;
  localparam int LNK_AW    = $clog2(LNK_COUNT);
  localparam int LNK_CW    = $clog2(LNK_COUNT + 1);
  localparam logic [15:0] LNK_LIMIT = 16'(LNK_COUNT);

  localparam logic [15:0] CHAIN_HEAD = 16'hFFFF;
  localparam logic [15:0] LINK_END   = 16'hFFFF;
  localparam int          CHAIN_BIT  = 15;

  localparam logic [3:0] DIR_MAX = 4'd14;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_MARK  = 1'b1;

  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_OLD     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  // bucket word: {mask[15:0], tile_or_link[15:0]}
  localparam int BKT_W = 32;
  // link word: {tile[15:0], mask[14:0], next[15:0]}
  localparam int LNK_W = 47;

  typedef logic [BKT_AW-1:0] bkt_idx_t;
  typedef logic [LNK_AW-1:0] lnk_idx_t;

  // (x & 31) | ((y & 31) << 5), reduced to the bucket range
  function automatic bkt_idx_t bucket_of(input logic [15:0] tile);
    logic [31:0] h;
    h = {22'd0, tile[12:8], tile[4:0]};
    return h[BKT_AW-1:0];
  endfunction

endpackage

FILE: rtl/visited_tile_direction_hash_set_unit.sv
// Visited set of (tile, direction) pairs: top level, sequencer and memories.
// Uses vtd_pkg, vtd_ram and the assertion macro header.
//
// Usage
//   Requests: pulse start with cmd/tile_index/direction_bit while busy is low;
//   the request is taken at that edge. cmd clear empties all buckets and
//   refills the link pool; cmd mark records one direction bit for a tile.
//   Results: status appears for one cycle with done high; no back-pressure,
//   the receiver must take it.
//   Config: cfg_we/cfg_wdata write bypass_marking (write only while idle).
// Sequence from request edge to done:
//   bypass or direction fifteen: answered from S_IDLE, and busy stays low.
//   mark hitting an empty or single-tile bucket: S_BRD, then S_NEWLINK
//   when a new tile collides with the single tile and takes a second link.
//   mark walking a chain: S_BRD, then S_LRD for each link visited, then
//   S_NEWLINK when a link is appended (the previous link's pointer and the
//   new link go through the one link RAM port in turn).
//   clear: S_CLR, one bucket row zeroed per cycle over all BKT_COUNT rows.
// One request at a time; the bucket RAM read latency and the chain walk,
// one link per cycle, set the rate.
// Reset: a clearing pass over all buckets runs with busy high and gives
// no result; config writes are still taken.
module visited_tile_direction_hash_set_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [15:0] tile_index,
  input  logic [3:0]  direction_bit,
  output logic        done,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

`include "visited_tile_direction_hash_set_unit_macros.svh"

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLR     = 3'd1; // zero sweep over bucket RAM
  localparam logic [2:0] S_BRD     = 3'd2; // bucket word is on the RAM output
  localparam logic [2:0] S_LRD     = 3'd3; // link word is on the RAM output
  localparam logic [2:0] S_NEWLINK = 3'd4; // write the freshly taken link

  localparam logic [vtd_pkg::BKT_AW-1:0] CLR_LAST =
    vtd_pkg::BKT_AW'(vtd_pkg::BKT_COUNT - 1);
  localparam logic [vtd_pkg::LNK_CW-1:0] NF_FULL = vtd_pkg::LNK_CW'(vtd_pkg::LNK_COUNT);
  localparam logic [vtd_pkg::LNK_CW-1:0] NF_LAST =
    vtd_pkg::LNK_CW'(vtd_pkg::LNK_COUNT - 1);

  // control registers
  logic [2:0]                  state, state_next;
  logic [vtd_pkg::BKT_AW-1:0]  clr_addr, clr_addr_next;
  logic                        clr_cmd, clr_cmd_next;
  logic [vtd_pkg::LNK_CW-1:0]  nf, nf_next;         // next free link
  logic                        done_next;
  logic                        bypass;

  // request context, no reset needed
  logic [15:0]                 tile_r, tile_r_next;
  logic [14:0]                 bit_r, bit_r_next;
  vtd_pkg::bkt_idx_t           bidx, bidx_next;
  vtd_pkg::lnk_idx_t           cur, cur_next;
  vtd_pkg::lnk_idx_t           fresh, fresh_next;
  logic [1:0]                  status_next;

  // memory ports
  logic                        b_we, b_re;
  vtd_pkg::bkt_idx_t           b_addr;
  logic [vtd_pkg::BKT_W-1:0]   b_wdata, b_rd;
  logic                        l_we, l_re;
  vtd_pkg::lnk_idx_t           l_addr;
  logic [vtd_pkg::LNK_W-1:0]   l_wdata, l_rd;

  logic [15:0] b_mask, b_tol, l_tile, l_next, nf_ptr;
  logic [14:0] l_mask;
  logic        full, second_ok;
  logic        bypass_take;   // mark request taken while bypass is on

  assign b_mask = b_rd[31:16];
  assign b_tol  = b_rd[15:0];
  assign l_tile = l_rd[46:31];
  assign l_mask = l_rd[30:16];
  assign l_next = l_rd[15:0];

  assign nf_ptr    = 16'(nf);
  assign full      = (nf == NF_FULL);
  assign second_ok = (nf != NF_LAST);
  assign busy      = (state != S_IDLE);

  assign bypass_take = start && !busy && (cmd == vtd_pkg::CMD_MARK) && bypass;

  vtd_ram #(.WIDTH(vtd_pkg::BKT_W), .DEPTH(vtd_pkg::BKT_COUNT)) u_bkt_ram (
    .clk   (clk),
    .we    (b_we),
    .re    (b_re),
    .addr  (b_addr),
    .wdata (b_wdata),
    .rdata (b_rd)
  );

  vtd_ram #(.WIDTH(vtd_pkg::LNK_W), .DEPTH(vtd_pkg::LNK_COUNT)) u_lnk_ram (
    .clk   (clk),
    .we    (l_we),
    .re    (l_re),
    .addr  (l_addr),
    .wdata (l_wdata),
    .rdata (l_rd)
  );

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    clr_cmd_next  = clr_cmd;
    nf_next       = nf;
    done_next     = 1'b0;
    status_next   = status;
    tile_r_next   = tile_r;
    bit_r_next    = bit_r;
    bidx_next     = bidx;
    cur_next      = cur;
    fresh_next    = fresh;
    b_we    = 1'b0;
    b_re    = 1'b0;
    b_addr  = bidx;
    b_wdata = '0;
    l_we    = 1'b0;
    l_re    = 1'b0;
    l_addr  = cur;
    l_wdata = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd == vtd_pkg::CMD_CLEAR) begin
            state_next    = S_CLR;
            clr_cmd_next  = 1'b1;
            clr_addr_next = '0;
            nf_next       = '0;
          end else if (bypass) begin
            done_next   = 1'b1;
            status_next = vtd_pkg::ST_NEW;
          end else if (direction_bit > vtd_pkg::DIR_MAX) begin
            // no bit in the mask for direction fifteen
            done_next   = 1'b1;
            status_next = vtd_pkg::ST_OLD;
          end else begin
            b_re        = 1'b1;
            b_addr      = vtd_pkg::bucket_of(tile_index);
            bidx_next   = vtd_pkg::bucket_of(tile_index);
            tile_r_next = tile_index;
            bit_r_next  = 15'd1 << direction_bit;
            state_next  = S_BRD;
          end
        end
      end

      S_CLR: begin
        b_we          = 1'b1;
        b_addr        = clr_addr;
        b_wdata       = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == CLR_LAST) begin
          state_next   = S_IDLE;
          done_next    = clr_cmd;
          status_next  = vtd_pkg::ST_CLEARED;
          clr_cmd_next = 1'b0;
        end
      end

      S_BRD: begin
        if (b_mask == 16'd0) begin
          // empty bucket takes the tile directly
          b_we        = 1'b1;
          b_wdata     = {1'b0, bit_r, tile_r};
          done_next   = 1'b1;
          status_next = vtd_pkg::ST_NEW;
          state_next  = S_IDLE;
        end else if (!b_mask[vtd_pkg::CHAIN_BIT]) begin
          if (b_tol == tile_r) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
            if (|(b_mask[14:0] & bit_r)) begin
              status_next = vtd_pkg::ST_OLD;
            end else begin
              b_we        = 1'b1;
              b_wdata     = {b_mask | {1'b0, bit_r}, b_tol};
              status_next = vtd_pkg::ST_NEW;
            end
          end else if (full) begin
            done_next   = 1'b1;
            status_next = vtd_pkg::ST_FULL;
            state_next  = S_IDLE;
          end else begin
            // collision: old tile moves to a link, bucket becomes a chain
            b_we    = 1'b1;
            b_wdata = {vtd_pkg::CHAIN_HEAD, nf_ptr};
            l_we    = 1'b1;
            l_addr  = nf[vtd_pkg::LNK_AW-1:0];
            if (second_ok) begin
              l_wdata    = {b_tol, b_mask[14:0], nf_ptr + 16'd1};
              fresh_next = vtd_pkg::LNK_AW'(nf + 1'b1);
              nf_next    = nf + vtd_pkg::LNK_CW'(2);
              state_next = S_NEWLINK;
            end else begin
              l_wdata     = {b_tol, b_mask[14:0], vtd_pkg::LINK_END};
              nf_next     = nf + 1'b1;
              done_next   = 1'b1;
              status_next = vtd_pkg::ST_FULL;
              state_next  = S_IDLE;
            end
          end
        end else if (b_tol >= vtd_pkg::LNK_LIMIT) begin
          // chain head out of the pool: new link hangs off the bucket
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (full) begin
            status_next = vtd_pkg::ST_FULL;
          end else begin
            b_we        = 1'b1;
            b_wdata     = {vtd_pkg::CHAIN_HEAD, nf_ptr};
            l_we        = 1'b1;
            l_addr      = nf[vtd_pkg::LNK_AW-1:0];
            l_wdata     = {tile_r, bit_r, vtd_pkg::LINK_END};
            nf_next     = nf + 1'b1;
            status_next = vtd_pkg::ST_NEW;
          end
        end else begin
          l_re       = 1'b1;
          l_addr     = b_tol[vtd_pkg::LNK_AW-1:0];
          cur_next   = b_tol[vtd_pkg::LNK_AW-1:0];
          state_next = S_LRD;
        end
      end

      S_LRD: begin
        if (l_tile == tile_r) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (|(l_mask & bit_r)) begin
            status_next = vtd_pkg::ST_OLD;
          end else begin
            l_we        = 1'b1;
            l_wdata     = {l_tile, l_mask | bit_r, l_next};
            status_next = vtd_pkg::ST_NEW;
          end
        end else if (l_next >= vtd_pkg::LNK_LIMIT) begin
          // end of chain: point the tail at a fresh link
          if (full) begin
            done_next   = 1'b1;
            status_next = vtd_pkg::ST_FULL;
            state_next  = S_IDLE;
          end else begin
            l_we       = 1'b1;
            l_wdata    = {l_tile, l_mask, nf_ptr};
            fresh_next = nf[vtd_pkg::LNK_AW-1:0];
            nf_next    = nf + 1'b1;
            state_next = S_NEWLINK;
          end
        end else begin
          l_re     = 1'b1;
          l_addr   = l_next[vtd_pkg::LNK_AW-1:0];
          cur_next = l_next[vtd_pkg::LNK_AW-1:0];
        end
      end

      S_NEWLINK: begin
        l_we        = 1'b1;
        l_addr      = fresh;
        l_wdata     = {tile_r, bit_r, vtd_pkg::LINK_END};
        done_next   = 1'b1;
        status_next = vtd_pkg::ST_NEW;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      clr_cmd  <= 1'b0;
      nf       <= '0;
      done     <= 1'b0;
      bypass   <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      clr_cmd  <= clr_cmd_next;
      nf       <= nf_next;
      done     <= done_next;
      if (cfg_we) begin
        bypass <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    tile_r <= tile_r_next;
    bit_r  <= bit_r_next;
    bidx   <= bidx_next;
    cur    <= cur_next;
    fresh  <= fresh_next;
  end

  `VTD_ASSERT_IMP(a_done_idle, done, !busy)
  `VTD_ASSERT_IMP(a_pool_range, 1'b1, nf <= NF_FULL)
  `VTD_ASSERT_NXT(a_bypass_new, bypass_take, done && status == vtd_pkg::ST_NEW)
  `VTD_ASSERT_IMP(a_clr_src, done && status == vtd_pkg::ST_CLEARED, $past(state) == S_CLR)
  `VTD_ASSERT_IMP(a_walk_no_write, state == S_LRD && l_re, !l_we && !b_we)

endmodule

FILE: rtl/vtd_ram.sv
// Generic single-port synchronous RAM, registered read, no reset.
// Standalone.
module vtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: tb/visited_tile_direction_hash_set_unit_tb.sv
// Self-checking bench for the visited tile/direction hash set: directed probes, a pool
// exhaustion sweep and random request traffic, all checked against a local predictor.
// Depends on vtd_pkg and the visited_tile_direction_hash_set_unit RTL.
`timescale 1ns / 1ps

module visited_tile_direction_hash_set_unit_tb;
  import vtd_pkg::*;

  localparam int QUIET_LIMIT = 8000;   // > reset sweep + clear + worst sender gap
  localparam int PROBE_COUNT = 19;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 24;

  // request as seen on the ports, plus the status it should produce
  typedef struct packed {
    logic        op;
    logic [15:0] tile;
    logic [3:0]  dir;
    logic [1:0]  st;
  } visit_req_t;

  // directed probe row; pin set means the status is typed in, not predicted
  typedef struct packed {
    logic        byp;
    logic        op;
    logic [15:0] tile;
    logic [3:0]  dir;
    logic        pin;
    logic [1:0]  st;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        cmd = CMD_CLEAR;
  logic [15:0] tile_index = '0;
  logic [3:0]  direction_bit = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        busy;
  logic        done;
  logic [1:0]  status;

  // travel alongside start so the monitor knows whether to trust a typed status
  logic        pin_valid = 1'b0;
  logic [1:0]  pin_status = ST_NEW;

  always #4 clk = ~clk;

  visited_tile_direction_hash_set_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .tile_index    (tile_index),
    .direction_bit (direction_bit),
    .done          (done),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the table, link pool and bypass register.
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_bkt_mask [BKT_COUNT];  // 0 empty, CHAIN_HEAD chain, else mask
  logic [15:0] shadow_bkt_ref  [BKT_COUNT];  // single tile or first link
  logic [15:0] shadow_lnk_tile [LNK_COUNT];
  logic [14:0] shadow_lnk_mask [LNK_COUNT];
  logic [15:0] shadow_lnk_next [LNK_COUNT];
  int unsigned links_free;
  int unsigned link_cursor;
  logic        bypass_on;

  visit_req_t  pending_visits [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          sender_idle_pct;

  // Hand out the next free link, if the pool still has one.
  function automatic bit grab_link(output int unsigned idx);
    idx = 0;
    if (links_free == 0 || link_cursor >= LNK_COUNT) return 1'b0;
    links_free--;
    idx = link_cursor;
    link_cursor++;
    return 1'b1;
  endfunction

  // Apply one request to the shadow table and return the status it earns.
  function automatic logic [1:0] visit_outcome(input logic op, input logic [15:0] tile,
                                               input logic [3:0] dir);
    int unsigned b;
    int unsigned cur;
    int unsigned last;
    int unsigned fresh;
    int unsigned n;
    logic [15:0] head;
    logic [15:0] bitm;
    if (op == CMD_CLEAR) begin
      for (int i = 0; i < BKT_COUNT; i++) shadow_bkt_mask[i] = '0;
      links_free  = LNK_COUNT;
      link_cursor = 0;
      return ST_CLEARED;
    end
    if (bypass_on) return ST_NEW;
    if (dir > DIR_MAX) return ST_OLD;   // direction fifteen has no mask bit
    b    = 32'({tile[12:8], tile[4:0]});
    bitm = 16'd1 << dir;
    head = shadow_bkt_mask[b];
    if (head == '0) begin
      shadow_bkt_mask[b] = bitm;
      shadow_bkt_ref[b]  = tile;
      return ST_NEW;
    end
    if (!head[CHAIN_BIT]) begin
      if (shadow_bkt_ref[b] == tile) begin
        if ((head & bitm) != '0) return ST_OLD;
        shadow_bkt_mask[b] = head | bitm;
        return ST_NEW;
      end
      // collision: old tile moves out into a link first
      if (!grab_link(last)) return ST_FULL;
      shadow_lnk_tile[last] = shadow_bkt_ref[b];
      shadow_lnk_mask[last] = head[14:0];
      shadow_lnk_next[last] = LINK_END;
      shadow_bkt_ref[b]     = 16'(last);
      shadow_bkt_mask[b]    = CHAIN_HEAD;
    end else begin
      cur  = 32'(shadow_bkt_ref[b]);
      last = LNK_COUNT;
      for (n = 0; n < LNK_COUNT && cur < LNK_COUNT; n++) begin
        if (shadow_lnk_tile[cur] == tile) begin
          if ((shadow_lnk_mask[cur] & bitm[14:0]) != '0) return ST_OLD;
          shadow_lnk_mask[cur] = shadow_lnk_mask[cur] | bitm[14:0];
          return ST_NEW;
        end
        last = cur;
        cur  = 32'(shadow_lnk_next[cur]);
        if (cur == 32'(LINK_END)) break;
      end
    end
    if (!grab_link(fresh)) return ST_FULL;
    shadow_lnk_tile[fresh] = tile;
    shadow_lnk_mask[fresh] = bitm[14:0];
    shadow_lnk_next[fresh] = LINK_END;
    if (last < LNK_COUNT) shadow_lnk_next[last] = 16'(fresh);
    else shadow_bkt_ref[b] = 16'(fresh);
    return ST_NEW;
  endfunction

  // i-th of the 64 tiles (0..63) that share bucket b
  function automatic logic [15:0] tile_in_bucket(input int b, input int i);
    logic [9:0] bb;
    logic [5:0] ii;
    bb = b[9:0];
    ii = i[5:0];
    return {ii[5:3], bb[9:5], ii[2:0], bb[4:0]};
  endfunction

  task automatic report_mismatch(input string what, input visit_req_t req,
                                 input logic [1:0] got);
    mismatch_count++;
    $display("%0t mismatch: %s (cmd=%0d tile=%h dir=%0d want=%0d got=%0d)",
             $time, what, req.op, req.tile, req.dir, req.st, got);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, before the block's own
  // updates land, so the order of processes within the step does not matter.
  // Results are checked before the new request is queued: a result can never
  // belong to a request taken at the same edge. A register write at the same
  // edge only affects later requests.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    visit_req_t req;
    if (rst) begin
      for (int i = 0; i < BKT_COUNT; i++) shadow_bkt_mask[i] = '0;
      links_free  = LNK_COUNT;
      link_cursor = 0;
      bypass_on   = 1'b0;
    end else begin
      if (done) begin
        if (pending_visits.size() == 0) begin
          req = '0;
          report_mismatch("status with no request pending", req, status);
        end else begin
          req = pending_visits.pop_front();
          if (status !== req.st) report_mismatch("status", req, status);
        end
      end
      if (start && !busy) begin
        req.op   = cmd;
        req.tile = tile_index;
        req.dir  = direction_bit;
        req.st   = visit_outcome(cmd, tile_index, direction_bit);
        if (pin_valid) req.st = pin_status;   // typed-in probe status wins
        pending_visits.push_back(req);
      end
      if (cfg_we) bypass_on = cfg_wdata;
    end
  end

  // Watchdog: a run of cycles with neither a request nor a result taken.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. Each returns at a rising edge; start is touched at most once
  // per step so a held-high start is never lowered and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_visit(input logic op, input logic [15:0] tile, input logic [3:0] dir,
                            input logic pin, input logic [1:0] pst);
    start         <= 1'b1;
    cmd           <= op;
    tile_index    <= tile;
    direction_bit <= dir;
    pin_valid     <= pin;
    pin_status    <= pst;
    do @(posedge clk); while (busy);
    // random gap after the request is taken
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
  endtask

  // Drop start and wait until every pending request has answered.
  task automatic drain_requests();
    start <= 1'b0;
    @(posedge clk);
    while (pending_visits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bypass(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  probe_row_t  probes [PROBE_COUNT];
  logic [19:0] seen_marks [$];   // {tile, dir} of recent marks, for repeat hits

  initial begin : stimulus
    logic        bypass_set;
    logic        op;
    logic [15:0] tile;
    logic [3:0]  dir;
    logic [19:0] pick;
    int          r;
    int          phase_bypass [RAND_PHASES];
    int          phase_idle [RAND_PHASES];

    sender_idle_pct = 0;

    // Probes: extremes of tile and direction, direction fifteen, collisions
    // into single-tile buckets, chain hits and appends, clear with and without
    // bypass. Statuses after a collision are left to the predictor.
    probes = '{
      '{1'b0, CMD_MARK,  16'h0000, 4'd0,  1'b1, ST_NEW},
      '{1'b0, CMD_MARK,  16'h0000, 4'd0,  1'b1, ST_OLD},
      '{1'b0, CMD_MARK,  16'h0000, 4'd14, 1'b1, ST_NEW},
      '{1'b0, CMD_MARK,  16'h0000, 4'd15, 1'b1, ST_OLD},
      '{1'b0, CMD_MARK,  16'hFFFF, 4'd14, 1'b1, ST_NEW},
      '{1'b0, CMD_MARK,  16'hFFFF, 4'd15, 1'b1, ST_OLD},
      '{1'b0, CMD_MARK,  16'h2020, 4'd3,  1'b0, ST_NEW},
      '{1'b0, CMD_MARK,  16'h0000, 4'd1,  1'b0, ST_NEW},
      '{1'b0, CMD_MARK,  16'h2020, 4'd3,  1'b0, ST_NEW},
      '{1'b0, CMD_MARK,  16'hE0E0, 4'd7,  1'b0, ST_NEW},
      '{1'b0, CMD_MARK,  16'hE0E0, 4'd7,  1'b0, ST_NEW},
      '{1'b0, CMD_MARK,  16'h1F1F, 4'd5,  1'b0, ST_NEW},
      '{1'b0, CMD_CLEAR, 16'h0000, 4'd0,  1'b1, ST_CLEARED},
      '{1'b0, CMD_MARK,  16'h2020, 4'd3,  1'b1, ST_NEW},
      '{1'b1, CMD_MARK,  16'h2020, 4'd3,  1'b1, ST_NEW},
      '{1'b1, CMD_MARK,  16'hABCD, 4'd15, 1'b1, ST_NEW},
      '{1'b1, CMD_CLEAR, 16'hFFFF, 4'd15, 1'b1, ST_CLEARED},
      '{1'b0, CMD_MARK,  16'h2020, 4'd3,  1'b1, ST_NEW},
      '{1'b0, CMD_MARK,  16'h2020, 4'd3,  1'b1, ST_OLD}
    };
    phase_bypass = '{0, 1, 0, 1, 0, 0};
    phase_idle   = '{24, 24, 78, 78, 0, 0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // the register is taken even while the reset sweep keeps busy high
    write_bypass(1'b0);
    bypass_set = 1'b0;

    // --- directed probes -------------------------------------------------
    for (int i = 0; i < PROBE_COUNT; i++) begin
      if (probes[i].byp != bypass_set) begin
        drain_requests();
        write_bypass(probes[i].byp);
        bypass_set = probes[i].byp;
      end
      send_visit(probes[i].op, probes[i].tile, probes[i].dir, probes[i].pin, probes[i].st);
    end

    // --- pool exhaustion --------------------------------------------------
    // 15 full buckets (64 links each) plus 63 tiles in a 16th take 1023 links.
    // Then a single-tile bucket collides with one link left (the old tile moves,
    // the new one does not fit), a chain append finds the pool empty, and
    // another single-tile bucket collides with no link at all.
    send_visit(CMD_CLEAR, 16'h0000, 4'd0, 1'b0, ST_NEW);
    for (int b = 0; b < 16; b++)
      for (int i = 0; i < (b == 15 ? 63 : 64); i++)
        send_visit(CMD_MARK, tile_in_bucket(b, i), 4'($urandom_range(0, 14)), 1'b0, ST_NEW);
    send_visit(CMD_MARK, tile_in_bucket(16, 0), 4'd2, 1'b0, ST_NEW);
    send_visit(CMD_MARK, tile_in_bucket(16, 1), 4'd2, 1'b0, ST_NEW);
    send_visit(CMD_MARK, tile_in_bucket(16, 2), 4'd2, 1'b0, ST_NEW);
    send_visit(CMD_MARK, tile_in_bucket(16, 0), 4'd9, 1'b0, ST_NEW);
    send_visit(CMD_MARK, tile_in_bucket(17, 0), 4'd4, 1'b0, ST_NEW);
    send_visit(CMD_MARK, tile_in_bucket(17, 1), 4'd4, 1'b0, ST_NEW);
    send_visit(CMD_MARK, tile_in_bucket(17, 0), 4'd4, 1'b0, ST_NEW);

    // --- random traffic ---------------------------------------------------
    // Most marks land in a handful of hot buckets so chains grow long; a share
    // repeats earlier marks to hit already-set bits; clears are rare since
    // each one sweeps every bucket.
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_requests();
      write_bypass(phase_bypass[p][0]);
      sender_idle_pct = phase_idle[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r    = $urandom_range(0, 99);
        op   = CMD_MARK;
        tile = 16'($urandom);
        dir  = 4'($urandom_range(0, 15));
        if (r < 2) begin
          op = CMD_CLEAR;
        end else if (r < 30 && seen_marks.size() != 0) begin
          pick = seen_marks[$urandom_range(0, seen_marks.size() - 1)];
          tile = pick[19:4];
          dir  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : pick[3:0];
        end else if (r >= 50) begin
          tile = tile_in_bucket(($urandom_range(0, 7) * 131) % BKT_COUNT,
                                $urandom_range(0, 63));
        end
        if (op == CMD_MARK) begin
          seen_marks.push_back({tile, dir});
          if (seen_marks.size() > 64) void'(seen_marks.pop_front());
        end
        send_visit(op, tile, dir, 1'b0, ST_NEW);
      end
    end

    drain_requests();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
